// ----- hdl/rstu_pkg.sv -----
// Shared types and constants for the radix string-to-unsigned converter.
`timescale 1ns / 1ps
`default_nettype none
package rstu_pkg;

    localparam int VALUE_BITS = 32;
    localparam int RADIX_W    = 6;
    localparam int CHAR_W     = 8;
    localparam int DIGIT_W    = 6;
    localparam int OFFSET_W   = 8;
    localparam int Q_DEPTH    = 2;
    localparam int Q_AW       = 1;

    localparam logic [DIGIT_W-1:0] DIGIT_NONE = 6'h3f;
    localparam logic [RADIX_W-1:0] MAX_RADIX  = 6'd36;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_CONV  = 2'd1,
        ST_BAD_BASE = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    // Classified character, as it travels from front to back.
    typedef struct packed {
        logic               nul;
        logic               space;
        logic               minus;
        logic               plus;
        logic               zero;
        logic               xchar;
        logic [DIGIT_W-1:0] digit;
    } cls_t;

endpackage
`default_nettype wire

// ----- hdl/rstu_front.sv -----
// Front end: accepts characters and classifies them for the conversion engine.
`timescale 1ns / 1ps
`default_nettype none
module rstu_front (
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [rstu_pkg::CHAR_W-1:0] ch,
    input  wire logic                       q_full,
    output logic                            push,
    output rstu_pkg::cls_t                  item
);
    import rstu_pkg::*;

    logic [DIGIT_W-1:0] digit;

    // Map letters and digits onto 0..35, everything else onto DIGIT_NONE.
    always_comb
    begin
        digit = DIGIT_NONE;
        if (ch >= 8'h30 && ch <= 8'h39)
        begin
            digit = DIGIT_W'(ch - 8'h30);
        end
        else if (ch >= 8'h61 && ch <= 8'h7a)
        begin
            digit = DIGIT_W'(ch - 8'h61 + 8'd10);
        end
        else if (ch >= 8'h41 && ch <= 8'h5a)
        begin
            digit = DIGIT_W'(ch - 8'h41 + 8'd10);
        end
    end

    always_comb
    begin
        item.nul   = (ch == 8'h00);
        item.space = (ch == 8'h20) || (ch >= 8'h09 && ch <= 8'h0d);
        item.minus = (ch == 8'h2d);
        item.plus  = (ch == 8'h2b);
        item.zero  = (ch == 8'h30);
        item.xchar = (ch == 8'h78) || (ch == 8'h58);
        item.digit = digit;
    end

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

endmodule
`default_nettype wire

// ----- hdl/rstu_queue.sv -----
// Short register queue between the classifier and the conversion engine.
`timescale 1ns / 1ps
`default_nettype none
module rstu_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  rstu_pkg::cls_t      push_item,
    output logic                full,
    output logic                q_valid,
    output rstu_pkg::cls_t      q_item,
    input  wire logic           pop
);
    import rstu_pkg::*;

    cls_t              mem_reg [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg;
    logic [Q_AW-1:0]   rd_ptr_reg;
    logic [Q_AW:0]     count_reg;
    logic [Q_AW:0]     count_next;

    assign full    = (count_reg == (Q_AW+1)'(Q_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Payload storage; no reset needed.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/rstu_back.sv -----
// Conversion engine: parse state, multiply-accumulate and the result register.
`timescale 1ns / 1ps
`default_nettype none
module rstu_back #(
    parameter int MAX_LEN = 255
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic [rstu_pkg::RADIX_W-1:0]    radix,
    input  wire logic                            q_valid,
    input  rstu_pkg::cls_t                       q_item,
    output logic                                 pop,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [rstu_pkg::VALUE_BITS-1:0]      value,
    output logic [rstu_pkg::OFFSET_W-1:0]        end_offset,
    output rstu_pkg::status_t                    status
);
    import rstu_pkg::*;

    localparam int PW    = $clog2(MAX_LEN + 1);
    localparam int EW    = (PW > OFFSET_W) ? PW : OFFSET_W;
    localparam int PRODW = VALUE_BITS + RADIX_W;
    localparam int SUMW  = PRODW + 1;

    typedef enum logic [2:0] {
        PH_SPACE,
        PH_FIRST,
        PH_ZERO,
        PH_XSEEN,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    function automatic logic base_bad(input logic [RADIX_W-1:0] r);
        return (r == RADIX_W'(1)) || (r > MAX_RADIX);
    endfunction

    phase_t                   phase_reg, phase_next;
    logic                     neg_reg, neg_next;
    logic [VALUE_BITS-1:0]    acc_reg, acc_next;
    logic                     ovf_reg, ovf_next;
    logic [RADIX_W-1:0]       base_reg, base_next;
    logic [PW-1:0]            pos_reg, pos_next;
    logic [PW-1:0]            cend_reg, cend_next;

    logic                     out_valid_reg, out_valid_next;
    logic [VALUE_BITS-1:0]    value_reg, value_next;
    logic [OFFSET_W-1:0]      end_reg, end_next;
    status_t                  status_reg, status_next;

    logic                     r_bad;
    logic                     start;
    logic                     prefix_zero;
    logic                     scan;
    logic [RADIX_W-1:0]       scan_base;
    logic                     take;
    logic [RADIX_W-1:0]       mac_base;
    logic [PRODW-1:0]         prod;
    logic [SUMW-1:0]          sum;
    logic [PW-1:0]            pos_inc;
    logic                     nul_bad;
    logic [EW-1:0]            cend_ext;

    assign r_bad = base_bad(radix);
    assign pop   = q_valid && (!q_item.nul || !out_valid_reg || out_ready);

    // One multiply-accumulate per character.
    assign prod = PRODW'(acc_reg) * PRODW'(mac_base);
    assign sum  = SUMW'(prod) + SUMW'(q_item.digit);

    assign pos_inc  = (pos_reg == PW'(MAX_LEN)) ? pos_reg : pos_reg + 1'b1;
    assign cend_ext = EW'(cend_reg);
    assign nul_bad  = (phase_reg == PH_SPACE || phase_reg == PH_FIRST) ?
                      r_bad : base_bad(base_reg);

    always_comb
    begin
        phase_next     = phase_reg;
        neg_next       = neg_reg;
        acc_next       = acc_reg;
        ovf_next       = ovf_reg;
        base_next      = base_reg;
        pos_next       = pos_reg;
        cend_next      = cend_reg;
        out_valid_next = out_valid_reg && !out_ready;
        value_next     = value_reg;
        end_next       = end_reg;
        status_next    = status_reg;
        start          = 1'b0;
        prefix_zero    = 1'b0;
        scan           = 1'b0;
        scan_base      = base_reg;
        take           = 1'b0;
        mac_base       = base_reg;

        if (pop && q_item.nul)
        begin
            // Build the result and return to the idle parse state.
            out_valid_next = 1'b1;
            value_next     = '0;
            end_next       = '0;
            if (nul_bad)
            begin
                status_next = ST_BAD_BASE;
            end
            else if (cend_reg == '0)
            begin
                status_next = ST_NO_CONV;
            end
            else
            begin
                end_next = (cend_ext > EW'(8'hff)) ? 8'hff : cend_ext[OFFSET_W-1:0];
                if (ovf_reg)
                begin
                    value_next  = '1;
                    status_next = ST_OVERFLOW;
                end
                else
                begin
                    value_next  = neg_reg ? (VALUE_BITS'(0) - acc_reg) : acc_reg;
                    status_next = ST_OK;
                end
            end
            phase_next = PH_SPACE;
            neg_next   = 1'b0;
            acc_next   = '0;
            ovf_next   = 1'b0;
            base_next  = '0;
            pos_next   = '0;
            cend_next  = '0;
        end
        else if (pop)
        begin
            case (phase_reg)
                PH_SPACE:
                begin
                    if (q_item.space)
                    begin
                        phase_next = PH_SPACE;
                    end
                    else if (q_item.minus)
                    begin
                        neg_next   = 1'b1;
                        phase_next = PH_FIRST;
                    end
                    else if (q_item.plus)
                    begin
                        phase_next = PH_FIRST;
                    end
                    else
                    begin
                        start = 1'b1;
                    end
                end
                PH_FIRST:
                begin
                    start = 1'b1;
                end
                PH_ZERO:
                begin
                    if (q_item.xchar)
                    begin
                        phase_next = PH_XSEEN;
                    end
                    else
                    begin
                        scan = 1'b1;
                    end
                end
                PH_XSEEN:
                begin
                    if (q_item.digit < DIGIT_W'(16))
                    begin
                        base_next = RADIX_W'(16);
                        mac_base  = RADIX_W'(16);
                        take      = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                    end
                end
                PH_DIGITS:
                begin
                    scan = 1'b1;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase

            // Latch the base at the first character after space and sign.
            if (start)
            begin
                base_next = radix;
                if (r_bad)
                begin
                    phase_next = PH_DONE;
                end
                else if ((radix == '0 || radix == RADIX_W'(16)) && q_item.zero)
                begin
                    base_next   = (radix == '0) ? RADIX_W'(8) : RADIX_W'(16);
                    mac_base    = base_next;
                    take        = 1'b1;
                    prefix_zero = 1'b1;
                end
                else
                begin
                    scan_base = (radix == '0) ? RADIX_W'(10) : radix;
                    base_next = scan_base;
                    scan      = 1'b1;
                end
            end

            if (scan)
            begin
                mac_base = scan_base;
                if (q_item.digit >= DIGIT_W'(scan_base))
                begin
                    phase_next = PH_DONE;
                end
                else
                begin
                    take = 1'b1;
                end
            end

            if (take)
            begin
                if (!ovf_reg)
                begin
                    acc_next = sum[VALUE_BITS-1:0];
                    ovf_next = |sum[SUMW-1:VALUE_BITS];
                end
                cend_next  = pos_inc;
                // Only a leading '0' that may open a prefix waits for an 'x'.
                phase_next = prefix_zero ? PH_ZERO : PH_DIGITS;
            end

            pos_next = pos_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SPACE;
            neg_reg       <= 1'b0;
            acc_reg       <= '0;
            ovf_reg       <= 1'b0;
            base_reg      <= '0;
            pos_reg       <= '0;
            cend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            neg_reg       <= neg_next;
            acc_reg       <= acc_next;
            ovf_reg       <= ovf_next;
            base_reg      <= base_next;
            pos_reg       <= pos_next;
            cend_reg      <= cend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        end_reg    <= end_next;
        status_reg <= status_next;
    end

    assign out_valid  = out_valid_reg;
    assign value      = value_reg;
    assign end_offset = end_reg;
    assign status     = status_reg;

`ifndef NO_ASSERTIONS
    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && q_item.nul) |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten while held");

    a_nul_resets_state: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && q_item.nul) |=> (phase_reg == PH_SPACE && pos_reg == '0 && cend_reg == '0))
        else $error("parse state not cleared after string end");

    a_end_within_position: assert property (@(posedge clk) disable iff (!rst_n)
        cend_reg <= pos_reg)
        else $error("consumed end passed the position");

    a_overflow_phase: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (phase_reg == PH_DIGITS || phase_reg == PH_DONE))
        else $error("overflow flagged outside digit scan");
`endif

endmodule
`default_nettype wire

// ----- hdl/radix_string_to_unsigned_core.sv -----
// Top level of the streaming string-to-unsigned converter.
`timescale 1ns / 1ps
`default_nettype none
// Converts a character stream into an unsigned number, one character per
// transaction on s_axis. A NUL character ends a string and yields exactly one
// result transaction on m_axis; other characters yield none. Leading white
// space and one sign are skipped, radix 0 auto-detects octal ("0") and hex
// ("0x") prefixes, radix 16 skips "0x" before a hex digit, radix 1 or above 36
// reports a bad base. The value wraps modulo 2^32 after '-' and saturates to
// all ones on overflow (status 3). Rate: one character per clock, sustained,
// with results also taken at one per clock; the figure is set by the single
// multiply-accumulate (32 x 6 bits) in the conversion engine. m_axis_tvalid
// is registered: the NUL passes through the queue, and the engine loads the
// result register as it pops it. The front classifier and the engine are
// decoupled by a two-entry queue, so a stalled m_axis only holds off input
// once the queue has filled. Write cfg_wdata (radix) only while no string is
// in flight.
module radix_string_to_unsigned_core #(
    parameter int MAX_LEN = 255
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [5:0]  cfg_wdata,      // radix
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] ch
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata    // [31:0] value, [39:32] end_offset,
                                             // [41:40] status, [47:42] zero
);
    import rstu_pkg::*;

    logic [RADIX_W-1:0]    radix_reg;
    logic                  q_full;
    logic                  push;
    cls_t                  push_item;
    logic                  q_valid;
    cls_t                  q_item;
    logic                  pop;
    logic [VALUE_BITS-1:0] value;
    logic [OFFSET_W-1:0]   end_offset;
    status_t               status;

    // Radix register; the engine latches it at the start of each number.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= '0;
        end
        else if (cfg_we)
        begin
            radix_reg <= cfg_wdata;
        end
    end

    // Classify each accepted character.
    rstu_front u_front (
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .ch       (s_axis_tdata),
        .q_full   (q_full),
        .push     (push),
        .item     (push_item)
    );

    // Decouple the classifier from the engine.
    rstu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (pop)
    );

    // Parse, accumulate and hold the result.
    rstu_back #(
        .MAX_LEN (MAX_LEN)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .radix      (radix_reg),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .value      (value),
        .end_offset (end_offset),
        .status     (status)
    );

    // Pack the result fields, lowest field first.
    assign m_axis_tdata = {6'd0, status, end_offset, value};

endmodule
`default_nettype wire

// ----- tb/rstu_conversion_checker.sv -----
// Checker for the string-to-unsigned converter: predicts each conversion and compares results.
`timescale 1ns / 1ps
module rstu_conversion_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [5:0]  cfg_wdata,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [47:0] m_axis_tdata,
    output int               mismatch_count,
    output int               results_due,
    output int               results_checked
);
    import rstu_pkg::*;

    localparam int         MAX_REPORTS = 10;
    localparam logic [7:0] POS_LIMIT   = 8'hff;
    localparam logic [7:0] NOT_A_DIGIT = 8'hff;
    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_CR       = 8'h0d;
    localparam logic [7:0] CH_SPACE    = " ";
    localparam logic [7:0] CH_PLUS     = "+";
    localparam logic [7:0] CH_MINUS    = "-";
    localparam logic [7:0] CH_0        = "0";
    localparam logic [7:0] CH_9        = "9";
    localparam logic [7:0] CH_LA       = "a";
    localparam logic [7:0] CH_LZ       = "z";
    localparam logic [7:0] CH_UA       = "A";
    localparam logic [7:0] CH_UZ       = "Z";
    localparam logic [7:0] CH_LX       = "x";
    localparam logic [7:0] CH_UX       = "X";

    typedef enum logic [2:0] {
        SCAN_SPACE,
        SCAN_SIGNED,
        SCAN_ZERO,
        SCAN_XSEEN,
        SCAN_DIGITS,
        SCAN_DONE
    } scan_phase_t;

    typedef struct packed {
        logic [31:0] value;
        logic [7:0]  end_offset;
        status_t     status;
    } conversion_t;

    conversion_t expected_conversions[$];

    logic [5:0]  radix;
    scan_phase_t phase;
    logic        negative;
    logic [31:0] accumulator;
    logic        overflowed;
    logic [5:0]  active_base;
    logic [7:0]  position;
    logic [7:0]  consumed_end;

    int mismatches = 0;
    int pending    = 0;
    int checked    = 0;

    assign mismatch_count  = mismatches;
    assign results_due     = pending;
    assign results_checked = checked;

    function automatic logic [7:0] digit_value(input logic [7:0] c);
        if (c >= CH_0 && c <= CH_9)
            return c - CH_0;
        if (c >= CH_LA && c <= CH_LZ)
            return c - CH_LA + 8'd10;
        if (c >= CH_UA && c <= CH_UZ)
            return c - CH_UA + 8'd10;
        return NOT_A_DIGIT;
    endfunction

    function automatic logic base_invalid(input logic [5:0] r);
        return (r == 6'd1) || (r > MAX_RADIX);
    endfunction

    task automatic clear_scan();
        phase        = SCAN_SPACE;
        negative     = 1'b0;
        accumulator  = '0;
        overflowed   = 1'b0;
        active_base  = '0;
        position     = '0;
        consumed_end = '0;
    endtask

    task automatic take_digit(input logic [7:0] d);
        logic [63:0] product;
        if (!overflowed)
        begin
            product = 64'(accumulator) * 64'(active_base) + 64'(d);
            if (product[63:32] != '0)
                overflowed = 1'b1;
            accumulator = product[31:0];
        end
        consumed_end = (position == POS_LIMIT) ? POS_LIMIT : position + 8'd1;
        phase        = SCAN_DIGITS;
    endtask

    task automatic scan_digit(input logic [7:0] c);
        logic [7:0] d;
        d = digit_value(c);
        if (d >= {2'b00, active_base})
            phase = SCAN_DONE;
        else
            take_digit(d);
    endtask

    // The radix is latched here, on the first character after space and sign.
    task automatic start_number(input logic [7:0] c);
        active_base = radix;
        if (base_invalid(radix))
        begin
            phase = SCAN_DONE;
        end
        else if ((radix == 6'd0 || radix == 6'd16) && c == CH_0)
        begin
            active_base = (radix == 6'd0) ? 6'd8 : 6'd16;
            take_digit(8'd0);
            phase = SCAN_ZERO;
        end
        else
        begin
            if (radix == 6'd0)
                active_base = 6'd10;
            scan_digit(c);
        end
    endtask

    task automatic finish_string();
        conversion_t res;
        logic        bad;
        if (phase == SCAN_SPACE || phase == SCAN_SIGNED)
            bad = base_invalid(radix);
        else
            bad = base_invalid(active_base);
        res = '{value: '0, end_offset: '0, status: ST_OK};
        if (bad)
            res.status = ST_BAD_BASE;
        else if (consumed_end == '0)
            res.status = ST_NO_CONV;
        else
        begin
            res.end_offset = consumed_end;
            if (overflowed)
            begin
                res.value  = '1;
                res.status = ST_OVERFLOW;
            end
            else
                res.value = negative ? -accumulator : accumulator;
        end
        expected_conversions.push_back(res);
        clear_scan();
    endtask

    task automatic convert_char(input logic [7:0] c);
        logic [7:0] d;
        if (c == CH_NUL)
        begin
            finish_string();
        end
        else
        begin
            case (phase)
                SCAN_SPACE:
                    if (!(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)))
                    begin
                        if (c == CH_MINUS)
                        begin
                            negative = 1'b1;
                            phase    = SCAN_SIGNED;
                        end
                        else if (c == CH_PLUS)
                            phase = SCAN_SIGNED;
                        else
                            start_number(c);
                    end
                SCAN_SIGNED:
                    start_number(c);
                SCAN_ZERO:
                    if (c == CH_LX || c == CH_UX)
                        phase = SCAN_XSEEN;
                    else
                        scan_digit(c);
                SCAN_XSEEN:
                begin
                    d = digit_value(c);
                    if (d < 8'd16)
                    begin
                        active_base = 6'd16;
                        take_digit(d);
                    end
                    else
                        phase = SCAN_DONE;
                end
                SCAN_DIGITS:
                    scan_digit(c);
                default:
                    ;
            endcase
            if (position != POS_LIMIT)
                position = position + 8'd1;
        end
    endtask

    task automatic check_result(input logic [47:0] word);
        conversion_t want;
        conversion_t got;
        got = '{value: word[31:0], end_offset: word[39:32], status: status_t'(word[41:40])};
        if (expected_conversions.size() == 0)
        begin
            if (mismatches < MAX_REPORTS)
                $display("%0t: unexpected result value %h end %0d status %0d", $realtime,
                         got.value, got.end_offset, got.status);
            mismatches++;
        end
        else
        begin
            want = expected_conversions.pop_front();
            if (got.value !== want.value || got.end_offset !== want.end_offset ||
                got.status !== want.status)
            begin
                if (mismatches < MAX_REPORTS)
                    $display("%0t: result %0d mismatch: expected %h/%0d/%0d, got %h/%0d/%0d",
                             $realtime, checked, want.value, want.end_offset, want.status,
                             got.value, got.end_offset, got.status);
                mismatches++;
            end
            checked++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix = '0;
            clear_scan();
            expected_conversions.delete();
            pending = 0;
        end
        else
        begin
            // A result never belongs to a NUL taken at the same edge: pop first.
            if (m_axis_tvalid && m_axis_tready)
                check_result(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                convert_char(s_axis_tdata);
            if (cfg_we)
                radix = cfg_wdata;
            pending = expected_conversions.size();
        end
    end

endmodule

// ----- tb/tb_radix_string_to_unsigned_core.sv -----
// Testbench top for the string-to-unsigned converter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
// The top only makes traffic. Strings go in as character transactions on
// s_axis, each ending in a NUL; the checker beside the block predicts every
// result from the same transactions and counts mismatches.
//
// Plan of the run:
//  - a short directed set under auto-detect: signed hex with a prefix, a
//    "0x" with no hex digit behind it, an octal run cut by '9', a decimal
//    overflow and an empty string;
//  - a random part over a list of radix settings (auto, 2, 8, 10, 16, 36, the
//    bad bases 1, 37 and 63, and random ones), mostly well-formed strings
//    with random content, some noise and trailing junk, and one string long
//    enough to saturate the position counter;
//  - idling goes through three phases (sender 33% / receiver 73%, then the
//    reverse, then none), and once the receiver holds off for a long stretch
//    so the character queue fills and the block stalls its input.
module tb_radix_string_to_unsigned_core;

    localparam int         CLK_HALF     = 5;
    localparam int         RESET_CYCLES = 8;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         CYCLE_LIMIT  = 400000;
    localparam int         SEG_ITEMS    = 75;
    localparam int         SEGMENTS     = 14;
    localparam int         PRESSURE_AT  = 400;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         LONG_PAD     = 260;
    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_PLUS      = "+";
    localparam logic [7:0] CH_MINUS     = "-";
    localparam logic [7:0] CH_SPACE     = " ";
    localparam logic [7:0] CH_0         = "0";
    localparam logic [7:0] CH_LA        = "a";
    localparam logic [7:0] CH_UA        = "A";
    localparam logic [7:0] CH_LG        = "g";
    localparam logic [7:0] CH_LX        = "x";
    localparam logic [7:0] CH_UX        = "X";
    localparam logic [7:0] BLANKS [6]   = '{" ", 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d};
    // Radix per random segment; segments 10 and 11 draw a random radix instead.
    localparam logic [5:0] RADIX_PLAN [SEGMENTS] =
        '{6'd0, 6'd16, 6'd10, 6'd2, 6'd36, 6'd8, 6'd1, 6'd37, 6'd63, 6'd0,
          6'd0, 6'd0, 6'd16, 6'd0};

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [5:0]  cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;     // [7:0] ch
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;     // [31:0] value, [39:32] end_offset, [41:40] status

    int mismatch_count;
    int results_due;
    int results_checked;

    int         send_idle_pct = 33;
    int         recv_idle_pct = 73;
    int         chars_sent    = 0;
    int         lines_sent    = 0;
    int         radix_writes  = 0;
    int         cycle_count   = 0;
    logic [7:0] line_buf[$];

    radix_string_to_unsigned_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    rstu_conversion_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .mismatch_count  (mismatch_count),
        .results_due     (results_due),
        .results_checked (results_checked)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_HALF) clk = ~clk;

    // Watchdog: a hung handshake ends the run here.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles", cycle_count);
        $display("CHECK FAILED");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off once enough characters
    // have gone in, so the character queue fills and s_axis_tready drops.
    initial
    begin
        int   hold_left;
        logic hold_done;
        hold_left     = 0;
        hold_done     = 1'b0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (!hold_done && chars_sent >= PRESSURE_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Send the buffered line plus its NUL. Enter and leave at a falling edge;
    // tvalid stays high on return, so between lines it drops only when idling.
    task automatic send_line();
        line_buf.push_back(CH_NUL);
        foreach (line_buf[i])
        begin
            while ($urandom_range(99) < send_idle_pct)
            begin
                s_axis_tvalid <= 1'b0;
                @(negedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= line_buf[i];
            @(posedge clk);
            while (!s_axis_tready)
                @(posedge clk);
            @(negedge clk);
            chars_sent++;
        end
        line_buf.delete();
        lines_sent++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endtask

    task automatic push_digit(input int d);
        if (d < 10)
            line_buf.push_back(8'(CH_0 + d));
        else if ($urandom_range(1))
            line_buf.push_back(8'(CH_LA + d - 10));
        else
            line_buf.push_back(8'(CH_UA + d - 10));
    endtask

    // Drop tvalid, wait for every expected result, then let the pipe go quiet.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (results_due != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_radix(input logic [5:0] r);
        cfg_we    <= 1'b1;
        cfg_wdata <= r;
        @(negedge clk);
        cfg_we    <= 1'b0;
        radix_writes++;
    endtask

    // Build one random line for radix r: mostly blanks, sign, optional prefix,
    // digits valid for the base and a little trailing junk; sometimes pure noise.
    task automatic compose_line(input logic [5:0] r);
        int base;
        int n;
        if ($urandom_range(99) < 15)
        begin
            repeat ($urandom_range(8)) line_buf.push_back(8'($urandom_range(1, 255)));
        end
        else
        begin
            repeat ($urandom_range(3)) line_buf.push_back(BLANKS[$urandom_range(5)]);
            case ($urandom_range(3))
                0:       line_buf.push_back(CH_PLUS);
                1:       line_buf.push_back(CH_MINUS);
                default: ;
            endcase
            base = (r == 6'd0 || r == 6'd1 || r > 6'd36) ? 10 : int'(r);
            n    = $urandom_range(9);
            if ((r == 6'd0 || r == 6'd16) && n < 3)
            begin
                line_buf.push_back(CH_0);
                line_buf.push_back($urandom_range(1) ? CH_LX : CH_UX);
                base = 16;
                // occasionally break the prefix with a non-hex letter
                if ($urandom_range(5) == 0)
                    line_buf.push_back(8'(CH_LG + $urandom_range(19)));
            end
            else if (r == 6'd0 && n < 5)
            begin
                line_buf.push_back(CH_0);
                base = 8;
            end
            n = ($urandom_range(3) == 0) ? $urandom_range(8, 14) : $urandom_range(7);
            repeat (n) push_digit($urandom_range(base - 1));
            repeat ($urandom_range(2)) line_buf.push_back(8'($urandom_range(1, 255)));
        end
    endtask

    initial
    begin
        logic [5:0] r;
        int         first_random;
        int         seg_start;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed set, auto-detect base.
        write_radix(6'd0);
        push_text(" -0x1F");
        send_line();
        push_text("0xg");
        send_line();
        push_text("09");
        send_line();
        push_text("4294967296");
        send_line();
        send_line();
        settle();

        first_random = chars_sent;
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            if (seg == 10)
                r = 6'($urandom_range(2, 36));
            else if (seg == 11)
                r = 6'($urandom_range(63));
            else
                r = RADIX_PLAN[seg];
            write_radix(r);
            // Saturate the position counter once: long blank run, then digits.
            if (seg == 0)
            begin
                repeat (LONG_PAD) line_buf.push_back(CH_SPACE);
                push_text("12345");
                send_line();
            end
            seg_start = chars_sent;
            while (chars_sent - seg_start < SEG_ITEMS)
            begin
                // Hold the idling phase according to how far the random part has got.
                if (chars_sent - first_random < 480)
                begin
                    send_idle_pct = 33;
                    recv_idle_pct = 73;
                end
                else if (chars_sent - first_random < 960)
                begin
                    send_idle_pct = 73;
                    recv_idle_pct = 33;
                end
                else
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                compose_line(r);
                send_line();
            end
            settle();
        end

        $display("Run covered %0d characters in %0d strings over %0d radix writes,",
                 chars_sent, lines_sent, radix_writes);
        $display("including bad bases, prefixes, overflow and a saturated offset; %0d results",
                 results_checked);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
